FILE: src/pqt_pkg.sv
`timescale 1ns / 1ps

package pqt_pkg;

   // Controller states.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_NORM,
      ST_SQ_X,
      ST_SQ_Y,
      ST_SQRT,
      ST_DIV_INIT,
      ST_DIV,
      ST_MUL_X,
      ST_MUL_Y,
      ST_EMIT
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       load;
      logic       norm_step;
      logic       sq_x;
      logic       sq_y;
      logic       sqrt_step;
      logic       div_init;
      logic       div_step;
      logic       mul_x;
      logic       mul_y;
      logic       emit_load;
      logic [2:0] vtx;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic have_prev;
      logic zero_seg;
      logic norm_done;
   } status_type;

   // Iteration counts and fixed widths of the normalization arithmetic.
   localparam int SQRT_STEPS = 24;
   localparam int DIV_STEPS  = 18;
   localparam int CNT_W      = 5;
   localparam int RAD_W      = 48;
   localparam int ROOT_W     = 24;
   localparam int SQREM_W    = 27;
   localparam int QUO_W      = 18;
   localparam int NUM_W      = 40;
   localparam int HW_W       = 18;
   localparam int MAG_W      = 20;
   localparam int OFF_W      = 21;

   localparam logic [2:0] LAST_VTX = 3'd5;

   // Road type codes.
   localparam logic [1:0] ROAD_AVENUE  = 2'd2;
   localparam logic [1:0] ROAD_HIGHWAY = 2'd3;

   // Quad corner indexes.
   localparam logic [1:0] PT_PREV_PLUS  = 2'd0;
   localparam logic [1:0] PT_PREV_MINUS = 2'd1;
   localparam logic [1:0] PT_CUR_MINUS  = 2'd2;
   localparam logic [1:0] PT_CUR_PLUS   = 2'd3;

   // Corner used by each of the six vertices of the two triangles.
   function automatic logic [1:0] vtx_point(input logic [2:0] k);
      logic [1:0] p;
      case (k)
         3'd0: p = PT_PREV_PLUS;
         3'd1: p = PT_PREV_MINUS;
         3'd2: p = PT_CUR_MINUS;
         3'd3: p = PT_PREV_PLUS;
         3'd4: p = PT_CUR_MINUS;
         3'd5: p = PT_CUR_PLUS;
         default: p = PT_PREV_PLUS;
      endcase
      return p;
   endfunction

endpackage

FILE: src/pqt_ctrl.sv
`timescale 1ns / 1ps

module pqt_ctrl
   import pqt_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_line_start,
   output logic       req_ready,
   input  logic       rsp_ready,
   output logic       rsp_valid,
   input  status_type status,
   output cmd_type    cmd
);

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // Next state and step counter.
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && !req_line_start && status.have_prev) begin
               state_in = ST_NORM;
            end
         end
         ST_NORM: begin
            if (status.zero_seg) begin
               state_in = ST_EMIT;
               cnt_in   = '0;
            end else if (status.norm_done) begin
               state_in = ST_SQ_X;
            end
         end
         ST_SQ_X: state_in = ST_SQ_Y;
         ST_SQ_Y: begin
            state_in = ST_SQRT;
            cnt_in   = '0;
         end
         ST_SQRT: begin
            if (cnt_ff == CNT_W'(SQRT_STEPS - 1)) begin
               state_in = ST_DIV_INIT;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_DIV_INIT: begin
            state_in = ST_DIV;
            cnt_in   = '0;
         end
         ST_DIV: begin
            if (cnt_ff == CNT_W'(DIV_STEPS - 1)) begin
               state_in = ST_MUL_X;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_MUL_X: state_in = ST_MUL_Y;
         ST_MUL_Y: begin
            state_in = ST_EMIT;
            cnt_in   = '0;
         end
         ST_EMIT: begin
            if (out_free) begin
               if (cnt_ff[2:0] == LAST_VTX) begin
                  state_in = ST_IDLE;
               end
               cnt_in = cnt_ff + 1'b1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath commands.
   always_comb begin
      cmd           = '0;
      cmd.vtx       = cnt_ff[2:0];
      cmd.load      = (state_ff == ST_IDLE) && req_valid;
      cmd.norm_step = (state_ff == ST_NORM) && !status.zero_seg && !status.norm_done;
      cmd.sq_x      = (state_ff == ST_SQ_X);
      cmd.sq_y      = (state_ff == ST_SQ_Y);
      cmd.sqrt_step = (state_ff == ST_SQRT);
      cmd.div_init  = (state_ff == ST_DIV_INIT);
      cmd.div_step  = (state_ff == ST_DIV);
      cmd.mul_x     = (state_ff == ST_MUL_X);
      cmd.mul_y     = (state_ff == ST_MUL_Y);
      cmd.emit_load = (state_ff == ST_EMIT) && out_free;
   end

   // Output valid follows vertex loads and consumer acceptance.
   always_comb begin
      if (cmd.emit_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // The sixth vertex load always returns the controller to idle.
   a_last_to_idle: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit_load && cmd.vtx == LAST_VTX) |=> (state_ff == ST_IDLE))
      else $error("controller did not return to idle after the last vertex");

   // At most one datapath operation per cycle.
   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.norm_step, cmd.sq_x, cmd.sq_y, cmd.sqrt_step,
                cmd.div_init, cmd.div_step, cmd.mul_x, cmd.mul_y, cmd.emit_load}))
      else $error("more than one datapath command active");

   // A new vertex never overwrites one that is still waiting.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |-> !cmd.emit_load)
      else $error("vertex loaded over a pending transaction");

endmodule

FILE: src/pqt_dp.sv
`timescale 1ns / 1ps

module pqt_dp
   import pqt_pkg::*;
#(
   parameter int COORD_BITS = 24
) (
   input  logic                         clock,
   input  logic                         reset,
   input  cmd_type                      cmd,
   output status_type                   status,
   input  logic signed [COORD_BITS-1:0] req_pt_x,
   input  logic signed [COORD_BITS-1:0] req_pt_y,
   input  logic [1:0]                   req_road_type,
   input  logic [15:0]                  req_base_width,
   input  logic [15:0]                  req_layer_height,
   input  logic [31:0]                  req_rgba_in,
   output logic signed [COORD_BITS-1:0] rsp_vert_x,
   output logic signed [COORD_BITS-1:0] rsp_vert_y,
   output logic [15:0]                  rsp_vert_z,
   output logic [31:0]                  rsp_rgba_out,
   output logic                         rsp_last_vertex
);

   localparam int D_W   = COORD_BITS + 1;
   localparam int SUM_W = ((COORD_BITS > OFF_W) ? COORD_BITS : OFF_W) + 2;

   // Point history and segment registers.
   logic signed [COORD_BITS-1:0] cur_x_ff, cur_y_ff, prv_x_ff, prv_y_ff;
   logic                         have_prev_ff;
   logic                         dx_neg_ff, dx_zero_ff, dy_pos_ff, dy_zero_ff;
   logic [D_W-1:0]               ax_ff, ay_ff;
   logic [HW_W-1:0]              hw4_ff;
   logic [15:0]                  height_ff;
   logic [31:0]                  rgba_ff;

   // Normalization arithmetic registers.
   logic [30:0]        sumsq_ff;
   logic [RAD_W-1:0]   rad_ff;
   logic [ROOT_W-1:0]  root_ff;
   logic [SQREM_W-1:0] sqrem_ff;
   logic [ROOT_W-1:0]  remx_ff, remy_ff;
   logic [QUO_W-1:0]   qx_ff, qy_ff;
   logic [MAG_W-1:0]   mx_ff, my_ff;

   // Output registers.
   logic signed [COORD_BITS-1:0] vx_ff, vy_ff;
   logic [15:0]                  vz_ff;
   logic [31:0]                  vrgba_ff;
   logic                         vlast_ff;

   // Segment vector from the previous point to the incoming one.
   logic signed [D_W-1:0] dx, dy;
   logic [D_W-1:0]        adx, ady;
   logic [HW_W-1:0]       hw4;
   always_comb begin
      dx  = D_W'(req_pt_x) - D_W'(cur_x_ff);
      dy  = D_W'(req_pt_y) - D_W'(cur_y_ff);
      adx = dx[D_W-1] ? D_W'(-dx) : D_W'(dx);
      ady = dy[D_W-1] ? D_W'(-dy) : D_W'(dy);
      case (req_road_type)
         ROAD_AVENUE:  hw4 = HW_W'(req_base_width) * HW_W'(3);
         ROAD_HIGHWAY: hw4 = HW_W'(req_base_width) * HW_W'(4);
         default:      hw4 = HW_W'(req_base_width) * HW_W'(2);
      endcase
   end

   // Magnitude range test for the power-of-two normalization.
   logic [D_W-1:0] maxv;
   logic           above, below;
   always_comb begin
      maxv  = (ax_ff > ay_ff) ? ax_ff : ay_ff;
      above = |maxv[D_W-1:15];
      below = ~|maxv[D_W-1:14];
   end

   assign status.have_prev = have_prev_ff;
   assign status.zero_seg  = (ax_ff == '0) && (ay_ff == '0);
   assign status.norm_done = !above && !below;

   // Squares, root step, divide steps and offset products.
   logic [29:0]        sqx, sqy;
   logic [SQREM_W-1:0] sq_t, sq_trial;
   logic [NUM_W-1:0]   numx, numy;
   logic [ROOT_W:0]    dvx_t, dvy_t;
   logic [35:0]        prod;
   logic [36:0]        prod_rnd;
   always_comb begin
      sqx      = ax_ff[14:0] * ax_ff[14:0];
      sqy      = ay_ff[14:0] * ay_ff[14:0];
      sq_t     = {sqrem_ff[SQREM_W-3:0], rad_ff[RAD_W-1 -: 2]};
      sq_trial = {1'b0, root_ff, 2'b01};
      numx     = NUM_W'({ax_ff[14:0], 23'b0}) + NUM_W'(root_ff[ROOT_W-1:1]);
      numy     = NUM_W'({ay_ff[14:0], 23'b0}) + NUM_W'(root_ff[ROOT_W-1:1]);
      dvx_t    = {remx_ff, qx_ff[QUO_W-1]};
      dvy_t    = {remy_ff, qy_ff[QUO_W-1]};
      prod     = (cmd.mul_x ? 36'(qy_ff) : 36'(qx_ff)) * 36'(hw4_ff);
      prod_rnd = 37'(prod) + 37'(1 << 16);
   end

   // Signed offsets along the perpendicular.
   logic signed [OFF_W-1:0] offx, offy, off_x_sel, off_y_sel;
   logic [1:0]              pt;
   logic signed [COORD_BITS-1:0] bx, by;
   logic signed [SUM_W-1:0] sx, sy;
   logic signed [SUM_W-1:0] sat_hi, sat_lo;
   logic signed [COORD_BITS-1:0] vx_in, vy_in;
   always_comb begin
      if (dy_zero_ff) begin
         offx = '0;
      end else if (dy_pos_ff) begin
         offx = -OFF_W'(mx_ff);
      end else begin
         offx = OFF_W'(mx_ff);
      end
      if (dx_zero_ff) begin
         offy = '0;
      end else if (dx_neg_ff) begin
         offy = -OFF_W'(my_ff);
      end else begin
         offy = OFF_W'(my_ff);
      end
      pt = vtx_point(cmd.vtx);
      bx = (pt == PT_PREV_PLUS || pt == PT_PREV_MINUS) ? prv_x_ff : cur_x_ff;
      by = (pt == PT_PREV_PLUS || pt == PT_PREV_MINUS) ? prv_y_ff : cur_y_ff;
      off_x_sel = (pt == PT_PREV_MINUS || pt == PT_CUR_MINUS) ? -offx : offx;
      off_y_sel = (pt == PT_PREV_MINUS || pt == PT_CUR_MINUS) ? -offy : offy;
      sx = SUM_W'(bx) + SUM_W'(off_x_sel);
      sy = SUM_W'(by) + SUM_W'(off_y_sel);
      sat_hi = SUM_W'({1'b0, {(COORD_BITS-1){1'b1}}});
      sat_lo = -sat_hi - SUM_W'(1);
      if (sx > sat_hi) begin
         vx_in = sat_hi[COORD_BITS-1:0];
      end else if (sx < sat_lo) begin
         vx_in = sat_lo[COORD_BITS-1:0];
      end else begin
         vx_in = sx[COORD_BITS-1:0];
      end
      if (sy > sat_hi) begin
         vy_in = sat_hi[COORD_BITS-1:0];
      end else if (sy < sat_lo) begin
         vy_in = sat_lo[COORD_BITS-1:0];
      end else begin
         vy_in = sy[COORD_BITS-1:0];
      end
   end

   // Previous point state.
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_x_ff     <= '0;
         cur_y_ff     <= '0;
         have_prev_ff <= 1'b0;
      end else if (cmd.load) begin
         cur_x_ff     <= req_pt_x;
         cur_y_ff     <= req_pt_y;
         have_prev_ff <= 1'b1;
      end
   end

   // Working registers.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         prv_x_ff   <= cur_x_ff;
         prv_y_ff   <= cur_y_ff;
         ax_ff      <= adx;
         ay_ff      <= ady;
         dx_neg_ff  <= dx[D_W-1];
         dx_zero_ff <= (dx == '0);
         dy_pos_ff  <= !dy[D_W-1] && (dy != '0);
         dy_zero_ff <= (dy == '0);
         hw4_ff     <= hw4;
         height_ff  <= req_layer_height;
         rgba_ff    <= req_rgba_in;
      end
      if (cmd.norm_step) begin
         if (above) begin
            ax_ff <= ax_ff >> 1;
            ay_ff <= ay_ff >> 1;
         end else begin
            ax_ff <= ax_ff << 1;
            ay_ff <= ay_ff << 1;
         end
      end
      if (cmd.sq_x) begin
         sumsq_ff <= 31'(sqx);
      end
      if (cmd.sq_y) begin
         rad_ff   <= {1'b0, sumsq_ff + 31'(sqy), 16'b0};
         root_ff  <= '0;
         sqrem_ff <= '0;
      end
      // One result bit of the square root per cycle.
      if (cmd.sqrt_step) begin
         rad_ff <= rad_ff << 2;
         if (sq_t >= sq_trial) begin
            sqrem_ff <= sq_t - sq_trial;
            root_ff  <= {root_ff[ROOT_W-2:0], 1'b1};
         end else begin
            sqrem_ff <= sq_t;
            root_ff  <= {root_ff[ROOT_W-2:0], 1'b0};
         end
      end
      if (cmd.div_init) begin
         remx_ff <= ROOT_W'(numx[NUM_W-1:QUO_W]);
         remy_ff <= ROOT_W'(numy[NUM_W-1:QUO_W]);
         qx_ff   <= numx[QUO_W-1:0];
         qy_ff   <= numy[QUO_W-1:0];
      end
      // One quotient bit of each unit component per cycle.
      if (cmd.div_step) begin
         if (dvx_t >= {1'b0, root_ff}) begin
            remx_ff <= ROOT_W'(dvx_t - {1'b0, root_ff});
            qx_ff   <= {qx_ff[QUO_W-2:0], 1'b1};
         end else begin
            remx_ff <= dvx_t[ROOT_W-1:0];
            qx_ff   <= {qx_ff[QUO_W-2:0], 1'b0};
         end
         if (dvy_t >= {1'b0, root_ff}) begin
            remy_ff <= ROOT_W'(dvy_t - {1'b0, root_ff});
            qy_ff   <= {qy_ff[QUO_W-2:0], 1'b1};
         end else begin
            remy_ff <= dvy_t[ROOT_W-1:0];
            qy_ff   <= {qy_ff[QUO_W-2:0], 1'b0};
         end
      end
      if (cmd.mul_x) begin
         mx_ff <= prod_rnd[36:17];
      end
      if (cmd.mul_y) begin
         my_ff <= prod_rnd[36:17];
      end
      if (cmd.emit_load) begin
         vx_ff    <= vx_in;
         vy_ff    <= vy_in;
         vz_ff    <= height_ff;
         vrgba_ff <= rgba_ff;
         vlast_ff <= (cmd.vtx == LAST_VTX);
      end
   end

   assign rsp_vert_x      = vx_ff;
   assign rsp_vert_y      = vy_ff;
   assign rsp_vert_z      = vz_ff;
   assign rsp_rgba_out    = vrgba_ff;
   assign rsp_last_vertex = vlast_ff;

endmodule

FILE: src/polyline_to_quad_triangles.sv
`timescale 1ns / 1ps
// A continuing point passes, in order, through 0 to 14 normalization shifts (more when
// COORD_BITS - 15 exceeds 14), two squares, 24 square-root steps, 18 divide steps and two
// offset products before its first vertex. A zero-length segment skips this arithmetic.
// Six vertices follow, one per cycle while the consumer is ready. One point is handled at a
// time: a new point is accepted only in idle, after the last vertex of a segment is loaded.
// Reset clears the previous point and marks it absent.

module polyline_to_quad_triangles
   import pqt_pkg::*;
#(
   parameter int COORD_BITS = 24
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic signed [COORD_BITS-1:0] req_pt_x,
   input  logic signed [COORD_BITS-1:0] req_pt_y,
   input  logic                         req_line_start,
   input  logic [1:0]                   req_road_type,
   input  logic [15:0]                  req_base_width,
   input  logic [15:0]                  req_layer_height,
   input  logic [31:0]                  req_rgba_in,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [COORD_BITS-1:0] rsp_vert_x,
   output logic signed [COORD_BITS-1:0] rsp_vert_y,
   output logic [15:0]                  rsp_vert_z,
   output logic [31:0]                  rsp_rgba_out,
   output logic                         rsp_last_vertex
);

   cmd_type    cmd;
   status_type status;

   // Sequencer for one transaction at a time.
   pqt_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_line_start (req_line_start),
      .req_ready      (req_ready),
      .rsp_ready      (rsp_ready),
      .rsp_valid      (rsp_valid),
      .status         (status),
      .cmd            (cmd)
   );

   // Arithmetic and vertex registers.
   pqt_dp #(
      .COORD_BITS (COORD_BITS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_pt_x         (req_pt_x),
      .req_pt_y         (req_pt_y),
      .req_road_type    (req_road_type),
      .req_base_width   (req_base_width),
      .req_layer_height (req_layer_height),
      .req_rgba_in      (req_rgba_in),
      .rsp_vert_x       (rsp_vert_x),
      .rsp_vert_y       (rsp_vert_y),
      .rsp_vert_z       (rsp_vert_z),
      .rsp_rgba_out     (rsp_rgba_out),
      .rsp_last_vertex  (rsp_last_vertex)
   );

endmodule

FILE: tb/polyline_to_quad_triangles_test.sv
`timescale 1ns / 1ps

module polyline_to_quad_triangles_test
   import pqt_pkg::*;
();

   localparam int COORD_W = 24;
   localparam longint COORD_HI = 64'sd8388607;
   localparam longint COORD_LO = -64'sd8388608;
   localparam int IDLE_LIMIT = 5000;
   localparam int RANDOM_POINTS = 103;

   // Road type codes that the package does not name.
   localparam logic [1:0] ROAD_UNDEFINED = 2'd0;
   localparam logic [1:0] ROAD_STREET    = 2'd1;

   // How the expected vertices of a directed row are obtained.
   typedef enum logic [1:0] {
      ROW_PREDICTED,
      ROW_SILENT,
      ROW_DEGENERATE
   } row_kind_type;

   typedef struct {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic                      start;
      logic [1:0]                road;
      logic [15:0]               width;
      logic [15:0]               height;
      logic [31:0]               rgba;
      row_kind_type              kind;
   } point_type;

   typedef struct {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic [15:0]               z;
      logic [31:0]               rgba;
      logic                      last;
   } vertex_type;

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_ready;
   logic signed [COORD_W-1:0] req_pt_x;
   logic signed [COORD_W-1:0] req_pt_y;
   logic                      req_line_start;
   logic [1:0]                req_road_type;
   logic [15:0]               req_base_width;
   logic [15:0]               req_layer_height;
   logic [31:0]               req_rgba_in;
   logic                      rsp_valid;
   logic                      rsp_ready;
   logic signed [COORD_W-1:0] rsp_vert_x;
   logic signed [COORD_W-1:0] rsp_vert_y;
   logic [15:0]               rsp_vert_z;
   logic [31:0]               rsp_rgba_out;
   logic                      rsp_last_vertex;

   // Predictor state: the previous point and whether one exists.
   logic signed [COORD_W-1:0] last_x;
   logic signed [COORD_W-1:0] last_y;
   logic                      last_valid;

   vertex_type pending_vertices[$];
   point_type  directed_points[$];
   int         error_count = 0;
   int         idle_cycles;
   logic       no_stall;

   polyline_to_quad_triangles #(
      .COORD_BITS(COORD_W)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_pt_x(req_pt_x),
      .req_pt_y(req_pt_y),
      .req_line_start(req_line_start),
      .req_road_type(req_road_type),
      .req_base_width(req_base_width),
      .req_layer_height(req_layer_height),
      .req_rgba_in(req_rgba_in),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_vert_x(rsp_vert_x),
      .rsp_vert_y(rsp_vert_y),
      .rsp_vert_z(rsp_vert_z),
      .rsp_rgba_out(rsp_rgba_out),
      .rsp_last_vertex(rsp_last_vertex)
   );

   // Clock generation.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Bitwise integer square root.
   function automatic longint unsigned int_sqrt(input longint unsigned n);
      longint unsigned root;
      longint unsigned bit_pos;
      root = 0;
      bit_pos = 64'd1 << 62;
      while (bit_pos > n) bit_pos = bit_pos >> 2;
      while (bit_pos != 0) begin
         if (n >= root + bit_pos) begin
            n = n - (root + bit_pos);
            root = (root >> 1) + bit_pos;
         end else begin
            root = root >> 1;
         end
         bit_pos = bit_pos >> 2;
      end
      return root;
   endfunction

   function automatic logic signed [COORD_W-1:0] clamp_coord(input longint v);
      if (v > COORD_HI) return COORD_HI[COORD_W-1:0];
      if (v < COORD_LO) return COORD_LO[COORD_W-1:0];
      return v[COORD_W-1:0];
   endfunction

   // Queues the six vertices of the quad extruded from the previous point to p.
   function automatic void push_quad(input point_type p);
      longint px, py, cx, cy, dx, dy, off_x, off_y;
      longint unsigned ax, ay, root, ux, uy, hw4, mag_x, mag_y;
      logic signed [COORD_W-1:0] cor_x[4];
      logic signed [COORD_W-1:0] cor_y[4];
      int order[6];
      vertex_type v;
      px = last_x;
      py = last_y;
      cx = p.x;
      cy = p.y;
      dx = cx - px;
      dy = cy - py;
      off_x = 0;
      off_y = 0;
      order = '{0, 1, 2, 0, 2, 3};
      ax = (dx < 0) ? -dx : dx;
      ay = (dy < 0) ? -dy : dy;
      if (ax != 0 || ay != 0) begin
         while (((ax > ay) ? ax : ay) >= (64'd1 << 15)) begin
            ax = ax >> 1;
            ay = ay >> 1;
         end
         while (((ax > ay) ? ax : ay) < (64'd1 << 14)) begin
            ax = ax << 1;
            ay = ay << 1;
         end
         root = int_sqrt((ax * ax + ay * ay) << 16);
         ux = ((ax << 23) + (root >> 1)) / root;
         uy = ((ay << 23) + (root >> 1)) / root;
         case (p.road)
            ROAD_AVENUE:  hw4 = p.width * 3;
            ROAD_HIGHWAY: hw4 = p.width * 4;
            default:      hw4 = p.width * 2;
         endcase
         mag_x = (uy * hw4 + (64'd1 << 16)) >> 17;
         mag_y = (ux * hw4 + (64'd1 << 16)) >> 17;
         off_x = (dy > 0) ? -longint'(mag_x) : longint'(mag_x);
         off_y = (dx < 0) ? -longint'(mag_y) : longint'(mag_y);
         if (dy == 0) off_x = 0;
         if (dx == 0) off_y = 0;
      end
      cor_x[0] = clamp_coord(px + off_x); cor_y[0] = clamp_coord(py + off_y);
      cor_x[1] = clamp_coord(px - off_x); cor_y[1] = clamp_coord(py - off_y);
      cor_x[2] = clamp_coord(cx - off_x); cor_y[2] = clamp_coord(cy - off_y);
      cor_x[3] = clamp_coord(cx + off_x); cor_y[3] = clamp_coord(cy + off_y);
      for (int k = 0; k < 6; k++) begin
         v.x = cor_x[order[k]];
         v.y = cor_y[order[k]];
         v.z = p.height;
         v.rgba = p.rgba;
         v.last = (k == 5);
         pending_vertices = {pending_vertices, v};
      end
   endfunction

   // Updates the predictor for one accepted point.
   function automatic void predict_point(input point_type p);
      vertex_type v;
      if (!p.start && last_valid) begin
         if (p.kind == ROW_DEGENERATE) begin
            // A zero-length segment collapses all six vertices onto the point.
            for (int k = 0; k < 6; k++) begin
               v.x = p.x;
               v.y = p.y;
               v.z = p.height;
               v.rgba = p.rgba;
               v.last = (k == 5);
               pending_vertices = {pending_vertices, v};
            end
         end else if (p.kind == ROW_PREDICTED) begin
            push_quad(p);
         end
      end
      last_x = p.x;
      last_y = p.y;
      last_valid = 1'b1;
   endfunction

   function automatic void add_row(input int x, input int y, input logic start,
                                   input logic [1:0] road, input int width,
                                   input row_kind_type kind);
      point_type p;
      p.x = x[COORD_W-1:0];
      p.y = y[COORD_W-1:0];
      p.start = start;
      p.road = road;
      p.width = width[15:0];
      p.height = 16'($urandom);
      p.rgba = $urandom;
      p.kind = kind;
      directed_points = {directed_points, p};
   endfunction

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 65) return 0;
      if (roll < 93) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Drives one point and waits until the transaction is accepted.
   task automatic send_point(input point_type p, input logic gaps);
      int gap;
      gap = gaps ? pick_gap() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_pt_x <= p.x;
      req_pt_y <= p.y;
      req_line_start <= p.start;
      req_road_type <= p.road;
      req_base_width <= p.width;
      req_layer_height <= p.height;
      req_rgba_in <= p.rgba;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_point(p);
   endtask

   // Random point: mostly short or medium steps from the previous point.
   function automatic point_type random_point(input logic start);
      point_type p;
      int mode;
      mode = $urandom_range(0, 9);
      p.start = start;
      p.road = 2'($urandom_range(0, 3));
      p.width = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 2048));
      p.height = 16'($urandom);
      p.rgba = $urandom;
      p.kind = ROW_PREDICTED;
      if (mode < 3) begin
         p.x = COORD_W'($urandom);
         p.y = COORD_W'($urandom);
      end else if (mode < 8) begin
         p.x = last_x + COORD_W'($signed($urandom_range(0, 8191)) - 4096);
         p.y = last_y + COORD_W'($signed($urandom_range(0, 8191)) - 4096);
      end else if (mode < 9) begin
         p.x = last_x;
         p.y = last_y + COORD_W'($signed($urandom_range(0, 255)) - 128);
      end else begin
         p.x = ($urandom_range(0, 1) == 1) ? COORD_HI[COORD_W-1:0] : COORD_LO[COORD_W-1:0];
         p.y = ($urandom_range(0, 1) == 1) ? COORD_HI[COORD_W-1:0] : COORD_LO[COORD_W-1:0];
      end
      return p;
   endfunction

   // Result side back-pressure, with stretches of no stalling.
   always @(posedge clock) begin
      if (reset || no_stall) begin
         rsp_ready <= 1'b1;
      end else if ($urandom_range(0, 99) < 3) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) < 70);
      end
   end

   // Result checking against the oldest expected vertex.
   always @(posedge clock) begin
      vertex_type v;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_vertices.size() == 0) begin
            $display("%0t: unexpected vertex x=%0d y=%0d", $time, rsp_vert_x, rsp_vert_y);
            error_count++;
         end else begin
            v = pending_vertices.pop_front();
            if (rsp_vert_x !== v.x) begin
               $display("%0t: vert_x expected %0d actual %0d", $time, v.x, rsp_vert_x);
               error_count++;
            end
            if (rsp_vert_y !== v.y) begin
               $display("%0t: vert_y expected %0d actual %0d", $time, v.y, rsp_vert_y);
               error_count++;
            end
            if (rsp_vert_z !== v.z) begin
               $display("%0t: vert_z expected %h actual %h", $time, v.z, rsp_vert_z);
               error_count++;
            end
            if (rsp_rgba_out !== v.rgba) begin
               $display("%0t: rgba_out expected %h actual %h", $time, v.rgba, rsp_rgba_out);
               error_count++;
            end
            if (rsp_last_vertex !== v.last) begin
               $display("%0t: last_vertex expected %b actual %b", $time, v.last,
                        rsp_last_vertex);
               error_count++;
            end
         end
      end
   end

   // Watchdog on cycles without any accepted transaction.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Stimulus.
   initial begin
      point_type p;
      int sent;
      int run_left;
      no_stall = 1'b0;
      last_x = '0;
      last_y = '0;
      last_valid = 1'b0;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_pt_x <= '0;
      req_pt_y <= '0;
      req_line_start <= 1'b0;
      req_road_type <= ROAD_STREET;
      req_base_width <= '0;
      req_layer_height <= '0;
      req_rgba_in <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Continuation with no previous point acts as a line start.
      add_row(0, 0, 1'b0, ROAD_STREET, 256, ROW_SILENT);
      add_row(256, 0, 1'b0, ROAD_STREET, 256, ROW_PREDICTED);
      add_row(256, 0, 1'b0, ROAD_HIGHWAY, 65535, ROW_DEGENERATE);
      add_row(256, 512, 1'b0, ROAD_UNDEFINED, 512, ROW_PREDICTED);
      add_row(-300, -700, 1'b0, ROAD_AVENUE, 1000, ROW_PREDICTED);
      add_row(100, 100, 1'b1, ROAD_HIGHWAY, 65535, ROW_SILENT);
      add_row(100, 100, 1'b0, ROAD_STREET, 0, ROW_DEGENERATE);
      add_row(8388607, 8388607, 1'b0, ROAD_HIGHWAY, 65535, ROW_PREDICTED);
      add_row(-8388608, -8388608, 1'b0, ROAD_HIGHWAY, 65535, ROW_PREDICTED);
      add_row(-8388608, 8388607, 1'b0, ROAD_AVENUE, 65535, ROW_PREDICTED);
      add_row(8388607, 8388607, 1'b0, ROAD_STREET, 65535, ROW_PREDICTED);
      add_row(8388607, -8388608, 1'b0, ROAD_HIGHWAY, 65535, ROW_PREDICTED);
      add_row(8388607, -8388607, 1'b0, ROAD_UNDEFINED, 1, ROW_PREDICTED);
      add_row(0, 0, 1'b1, ROAD_STREET, 0, ROW_SILENT);
      add_row(0, 1, 1'b0, ROAD_AVENUE, 32768, ROW_PREDICTED);
      add_row(1, 1, 1'b0, ROAD_HIGHWAY, 32768, ROW_PREDICTED);
      add_row(-1, 0, 1'b0, ROAD_STREET, 65535, ROW_PREDICTED);

      foreach (directed_points[i]) send_point(directed_points[i], 1'b1);

      // The sender holds off until every expected vertex has arrived.
      req_valid <= 1'b0;
      while (pending_vertices.size() != 0) @(posedge clock);

      // Random polylines, with occasional stray starts and no-gap stretches.
      sent = 0;
      while (sent < RANDOM_POINTS) begin
         run_left = $urandom_range(2, 8);
         no_stall = ($urandom_range(0, 4) == 0);
         send_point(random_point(1'b1), 1'b1);
         sent++;
         while (run_left > 0 && sent < RANDOM_POINTS) begin
            p = random_point($urandom_range(0, 19) == 0);
            send_point(p, !no_stall);
            sent++;
            run_left--;
         end
      end
      req_valid <= 1'b0;
      no_stall = 1'b0;

      while (pending_vertices.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (error_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
